// File: rtl/core/lud_pkg.sv
// ----------------------------------------------------------------------------
// lud_pkg
// Shared types and constants of the lenient UTF-8 byte decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lud_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] Lead2Mask  = 8'hE0;
  localparam logic [7:0] Lead2Pat   = 8'hC0;
  localparam logic [7:0] Lead3Mask  = 8'hF0;
  localparam logic [7:0] Lead3Pat   = 8'hE0;
  localparam logic [7:0] Lead4Mask  = 8'hF8;
  localparam logic [7:0] Lead4Pat   = 8'hF0;

  // one decoded result
  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           run_last;
  } result_t;

  // decoder state update and results for one byte
  typedef struct packed {
    logic [1:0]     be_d;
    logic [1:0]     hc_d;
    logic           held_we;
    logic [1:0]     held_idx;
    logic [1:0]     res_cnt;
    logic [CpW-1:0] cp0;
    logic [CpW-1:0] cp1;
  } step_t;

  // result buffer status
  typedef struct packed {
    logic       can_load;
    logic [1:0] count;
  } rbuf_stat_t;

  // sequence length from a lead byte, 0 when the byte cannot lead
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b < AsciiLimit)                  len = 3'd1;
    else if ((b & Lead2Mask) == Lead2Pat) len = 3'd2;
    else if ((b & Lead3Mask) == Lead3Pat) len = 3'd3;
    else if ((b & Lead4Mask) == Lead4Pat) len = 3'd4;
    return len;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/lud_in_if.sv
// ----------------------------------------------------------------------------
// lud_in_if
// Byte channel into the decoder: valid/ready with byte and end flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lud_out_if.sv
// ----------------------------------------------------------------------------
// lud_out_if
// Code point channel out of the decoder: valid/ready with result fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lud_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        run_last;

  modport source (output valid, output code_point, output run_last, input ready);
  modport sink   (input valid, input code_point, input run_last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lud_step.sv
// ----------------------------------------------------------------------------
// lud_step
// Combinational decode of one byte against the open sequence state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lud_step
  import lud_pkg::*;
(
  input  logic [1:0] be_i,
  input  logic [1:0] hc_i,
  input  logic [7:0] held_i [3],
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output step_t      step_o
);

  logic [2:0] lead;
  logic [7:0] h0, h1, h2;

  assign lead = lead_len(byte_i);
  assign h0   = held_i[0];
  assign h1   = held_i[1];
  assign h2   = held_i[2];

  always_comb begin
    step_o          = '0;
    step_o.be_d     = be_i;
    step_o.hc_d     = hc_i;
    step_o.held_idx = hc_i;

    case (be_i)
      2'd0: begin
        if (lead == 3'd1) begin
          step_o.res_cnt = 2'd1;
          step_o.cp0     = {13'd0, byte_i};
        end else if (lead >= 3'd2 && !last_i) begin
          step_o.held_we  = 1'b1;
          step_o.held_idx = 2'd0;
          step_o.hc_d     = 2'd1;
          step_o.be_d     = lead[1:0] - 2'd1;
        end
      end
      2'd1: begin
        // final byte of the sequence: pack held bytes with this one
        step_o.res_cnt = 2'd1;
        case (hc_i)
          2'd1:    step_o.cp0 = {10'd0, h0[4:0], byte_i[5:0]};
          2'd2:    step_o.cp0 = {5'd0, h0[3:0], h1[5:0], byte_i[5:0]};
          2'd3:    step_o.cp0 = {h0[2:0], h1[5:0], h2[5:0], byte_i[5:0]};
          default: step_o.cp0 = {13'd0, byte_i};
        endcase
        step_o.be_d = 2'd0;
        step_o.hc_d = 2'd0;
      end
      default: begin
        step_o.held_we = (hc_i != 2'd3);
        step_o.hc_d    = (hc_i != 2'd3) ? hc_i + 2'd1 : hc_i;
        step_o.be_d    = be_i - 2'd1;
        if (last_i) begin
          // truncated sequence: drop lead, re-decode bytes after it
          if (hc_i == 2'd1) begin
            if (!byte_i[7]) begin
              step_o.res_cnt = 2'd1;
              step_o.cp0     = {13'd0, byte_i};
            end
          end else if (hc_i == 2'd2) begin
            if (!h1[7]) begin
              step_o.cp0 = {13'd0, h1};
              if (!byte_i[7]) begin
                step_o.res_cnt = 2'd2;
                step_o.cp1     = {13'd0, byte_i};
              end else begin
                step_o.res_cnt = 2'd1;
              end
            end else if ((h1 & Lead2Mask) == Lead2Pat) begin
              step_o.res_cnt = 2'd1;
              step_o.cp0     = {10'd0, h1[4:0], byte_i[5:0]};
            end else if (!byte_i[7]) begin
              step_o.res_cnt = 2'd1;
              step_o.cp0     = {13'd0, byte_i};
            end
          end
        end
      end
    endcase

    if (last_i) begin
      step_o.be_d = 2'd0;
      step_o.hc_d = 2'd0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lud_rbuf.sv
// ----------------------------------------------------------------------------
// lud_rbuf
// Two-slot result register; loads up to two results, drains one per cycle when out_ready_i is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lud_rbuf
  import lud_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  logic [1:0] cnt_i,
  input  result_t    res0_i,
  input  result_t    res1_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output result_t    head_o,
  output rbuf_stat_t stat_o
);

  logic [1:0] cnt_q, cnt_d;
  result_t    slot0_q, slot1_q;
  logic       pop;

  assign out_valid_o     = (cnt_q != 2'd0);
  assign head_o          = slot0_q;
  assign pop             = out_valid_o && out_ready_i;
  assign stat_o.count    = cnt_q;
  assign stat_o.can_load = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

  always_comb begin
    cnt_d = cnt_q;
    if (load_i)   cnt_d = cnt_i;
    else if (pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot0_q <= res0_i;
      slot1_q <= res1_i;
    end else if (pop && cnt_q == 2'd2) begin
      slot0_q <= slot1_q;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lenient_utf8_byte_decoder_core.sv
// ----------------------------------------------------------------------------
// lenient_utf8_byte_decoder_core
// Lenient UTF-8 decoder: one text byte per transfer in, code points out.
// ----------------------------------------------------------------------------
// Accepts one byte per cycle while the result register can load. A byte
// passes an input register, is decoded against the open-sequence state,
// and its zero, one or two code points land in a two-slot result register
// that feeds the output. Output drains one code point per cycle while
// ready is high, so a byte that yields two code points (only at a text end
// inside a sequence) holds the input back; all other bytes sustain one
// transfer per cycle while the output is ready. Continuation bytes are
// packed without checking their 10xxxxxx pattern; lone continuation bytes
// and F8-FF are dropped. run_last marks the final code point caused by a byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lenient_utf8_byte_decoder_core
  import lud_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  lud_in_if.sink   in_i,
  lud_out_if.source out_o
);

  // input register
  logic       a_valid_q;
  logic [7:0] a_byte_q;
  logic       a_eot_q;
  logic       a_move;

  // sequence state
  logic [1:0] be_q, hc_q;
  logic [7:0] held_q [3];

  step_t      step;
  result_t    res0, res1, head;
  rbuf_stat_t rb_stat;

  // the input register refills in the cycle it hands its byte on
  assign a_move     = a_valid_q && rb_stat.can_load;
  assign in_i.ready = !a_valid_q || rb_stat.can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      a_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      a_byte_q <= in_i.data_byte;
      a_eot_q  <= in_i.end_of_text;
    end
  end

  lud_step u_step (
    .be_i   (be_q),
    .hc_i   (hc_q),
    .held_i (held_q),
    .byte_i (a_byte_q),
    .last_i (a_eot_q),
    .step_o (step)
  );

  // state advances only when the byte commits its results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      be_q <= 2'd0;
      hc_q <= 2'd0;
    end else if (a_move) begin
      be_q <= step.be_d;
      hc_q <= step.hc_d;
    end
  end

  // held bytes need no reset: only entries of the open sequence are read
  always_ff @(posedge clk_i) begin
    if (a_move && step.held_we) begin
      held_q[step.held_idx] <= a_byte_q;
    end
  end

  // run_last goes on the final result of the byte
  assign res0.code_point = step.cp0;
  assign res0.run_last   = (step.res_cnt == 2'd1);
  assign res1.code_point = step.cp1;
  assign res1.run_last   = 1'b1;

  lud_rbuf u_rbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (a_move),
    .cnt_i       (step.res_cnt),
    .res0_i      (res0),
    .res1_i      (res1),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .head_o      (head),
    .stat_o      (rb_stat)
  );

  assign out_o.code_point = head.code_point;
  assign out_o.run_last   = head.run_last;

`ifndef SYNTHESIS
  // an open sequence always holds its lead byte
  a_open_holds_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (be_q != 2'd0) |-> (hc_q != 2'd0))
    else $error("open sequence without held lead byte");

  // held plus expected never exceeds a four-byte sequence
  a_seq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (be_q != 2'd0) |-> (({1'b0, be_q} + {1'b0, hc_q}) <= 3'd4))
    else $error("sequence state out of range");

  // end of text always leaves the decoder idle
  a_eot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_move && a_eot_q) |=> (be_q == 2'd0 && hc_q == 2'd0))
    else $error("state not cleared after end of text");

  // a result without run_last must have its partner still buffered
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.run_last) |-> (rb_stat.count == 2'd2))
    else $error("non-final result without a following result");
`endif

endmodule

`default_nettype wire
